/* rtl/vssrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssrm_pkg
// Types and codes shared by the vertex slice range merger modules.
// ----------------------------------------------------------------------------
package vssrm_pkg;

   localparam int INDEX_W = 12;
   localparam int DATA_W  = 32;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [INDEX_W-1:0] slice_index;
      logic [DATA_W-1:0]  range_verts;
      logic [DATA_W-1:0]  range_elems;
      logic [DATA_W-1:0]  range_first_vert;
      logic [DATA_W-1:0]  range_first_elem;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_first_vert;
      logic [DATA_W-1:0] out_first_elem;
      logic [DATA_W-1:0] out_verts;
      logic [DATA_W-1:0] out_elems;
      logic [DATA_W-1:0] total_verts;
      logic [DATA_W-1:0] total_elems;
      logic              bad_index;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] first_vert;
      logic [DATA_W-1:0] first_elem;
      logic [DATA_W-1:0] vert_count;
      logic [DATA_W-1:0] elem_count;
   } slice_entry_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
      slice_entry_type    data;
   } slice_write_type;

endpackage

/* rtl/vssrm_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssrm_store
// Slice table memory: one registered read port, one write port, and a
// sweep that marks every entry empty after reset and after a clear.
// ----------------------------------------------------------------------------
module vssrm_store #(
   parameter int SLICE_COUNT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [vssrm_pkg::INDEX_W-1:0]        rd_addr,
   output vssrm_pkg::slice_entry_type           rd_data,
   input  vssrm_pkg::slice_write_type           wr,
   input  logic                                 clear_start,
   output logic                                 sweep_busy
);
   import vssrm_pkg::*;

   localparam int AW = (SLICE_COUNT > 1) ? $clog2(SLICE_COUNT) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(SLICE_COUNT - 1);

   slice_entry_type slice_mem [SLICE_COUNT];
   slice_entry_type rd_data_ff;

   logic          sweep_ff;
   logic          sweep_in;
   logic [AW-1:0] sweep_addr_ff;
   logic [AW-1:0] sweep_addr_in;

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (clear_start) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + AW'(1);
         if (sweep_addr_ff == LAST_ADDR) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         slice_mem[sweep_addr_ff] <= '0;
      end else if (wr.en) begin
         slice_mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slice_mem[rd_addr[AW-1:0]];
      end
   end

   assign rd_data    = rd_data_ff;
   assign sweep_busy = sweep_ff;

endmodule

/* rtl/vssrm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssrm_merge
// Merges one range into a slice entry: take, prepend or append.
// ----------------------------------------------------------------------------
module vssrm_merge (
   input  vssrm_pkg::slice_entry_type           cur,
   input  vssrm_pkg::req_type                   req,
   output vssrm_pkg::slice_entry_type           merged,
   output logic [vssrm_pkg::DATA_W-1:0]         old_verts,
   output logic [vssrm_pkg::DATA_W-1:0]         old_elems
);
   import vssrm_pkg::*;

   logic              empty;
   logic              prepend;
   logic [DATA_W-1:0] ext_verts;
   logic [DATA_W-1:0] ext_elems;

   always_comb begin
      old_verts = cur.valid ? cur.vert_count : '0;
      old_elems = cur.valid ? cur.elem_count : '0;
      empty     = !cur.valid || (cur.vert_count == '0);
      prepend   = req.range_first_vert < cur.first_vert;
      ext_verts = req.range_verts + req.range_first_vert - cur.first_vert;
      ext_elems = req.range_elems + req.range_first_elem - cur.first_elem;

      merged.valid = 1'b1;
      if (empty) begin
         merged.first_vert = req.range_first_vert;
         merged.first_elem = req.range_first_elem;
         merged.vert_count = req.range_verts;
         merged.elem_count = req.range_elems;
      end else if (prepend) begin
         merged.first_vert = req.range_first_vert;
         merged.first_elem = req.range_first_elem;
         merged.vert_count = old_verts + cur.first_vert - req.range_first_vert;
         merged.elem_count = old_elems + cur.first_elem - req.range_first_elem;
      end else begin
         merged.first_vert = cur.first_vert;
         merged.first_elem = cur.first_elem;
         merged.vert_count = (ext_verts > old_verts) ? ext_verts : old_verts;
         merged.elem_count = (ext_elems > old_elems) ? ext_elems : old_elems;
      end
   end

endmodule

/* rtl/vertex_slice_range_merger_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_slice_range_merger_unit
// Slice table with range merge, read, clear and running vertex/element totals.
// ----------------------------------------------------------------------------
// Stage 1 registers the request and the table read; the output register holds the result.
// Throughput: one add or read per cycle while busy is low; the table
// read-modify-write with a one-entry write forward sets this. A clear holds busy
// high while the memory sweep marks every slice empty.
// Reset: the same sweep runs after reset, busy high meanwhile.
// Results cannot be stalled; rsp_strobe marks each beat for one cycle.
module vertex_slice_range_merger_unit #(
   parameter int SLICE_COUNT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  vssrm_pkg::req_type    req_data,
   output logic                  rsp_strobe,
   output vssrm_pkg::rsp_type    rsp_data
);
   import vssrm_pkg::*;

   localparam logic [INDEX_W:0] SLICE_LIMIT = (INDEX_W + 1)'(SLICE_COUNT);

   logic            accept;
   logic            sweep_busy;
   slice_entry_type rd_data;
   slice_write_type wr;

   logic            s1_valid_ff;
   req_type         s1_req_ff;

   logic               fwd_valid_ff;
   logic               fwd_valid_in;
   logic [INDEX_W-1:0] fwd_index_ff;
   slice_entry_type    fwd_entry_ff;

   logic [DATA_W-1:0] vert_total_ff;
   logic [DATA_W-1:0] vert_total_in;
   logic [DATA_W-1:0] elem_total_ff;
   logic [DATA_W-1:0] elem_total_in;

   logic            rsp_strobe_ff;
   rsp_type         rsp_data_ff;
   rsp_type         rsp_data_in;

   slice_entry_type   cur;
   slice_entry_type   merged;
   logic [DATA_W-1:0] old_verts;
   logic [DATA_W-1:0] old_elems;
   logic              is_clear;
   logic              is_bad;
   logic              is_add;

   assign busy   = sweep_busy;
   assign accept = start && !sweep_busy;

   vssrm_store #(
      .SLICE_COUNT(SLICE_COUNT)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_addr     (req_data.slice_index),
      .rd_data     (rd_data),
      .wr          (wr),
      .clear_start (accept && (req_data.cmd == CMD_CLEAR)),
      .sweep_busy  (sweep_busy)
   );

   assign cur = (fwd_valid_ff && (fwd_index_ff == s1_req_ff.slice_index)) ?
                fwd_entry_ff : rd_data;

   vssrm_merge u_merge (
      .cur       (cur),
      .req       (s1_req_ff),
      .merged    (merged),
      .old_verts (old_verts),
      .old_elems (old_elems)
   );

   always_comb begin
      is_clear = s1_req_ff.cmd == CMD_CLEAR;
      is_bad   = !is_clear && ({1'b0, s1_req_ff.slice_index} >= SLICE_LIMIT);
      is_add   = (s1_req_ff.cmd == CMD_ADD) && !is_bad;

      wr.en   = s1_valid_ff && is_add;
      wr.addr = s1_req_ff.slice_index;
      wr.data = merged;

      fwd_valid_in  = fwd_valid_ff;
      vert_total_in = vert_total_ff;
      elem_total_in = elem_total_ff;
      if (s1_valid_ff && is_clear) begin
         fwd_valid_in  = 1'b0;
         vert_total_in = '0;
         elem_total_in = '0;
      end else if (wr.en) begin
         fwd_valid_in  = 1'b1;
         vert_total_in = vert_total_ff + merged.vert_count - old_verts;
         elem_total_in = elem_total_ff + merged.elem_count - old_elems;
      end

      rsp_data_in             = '0;
      rsp_data_in.total_verts = vert_total_in;
      rsp_data_in.total_elems = elem_total_in;
      rsp_data_in.bad_index   = is_bad;
      if (is_add) begin
         rsp_data_in.out_first_vert = merged.first_vert;
         rsp_data_in.out_first_elem = merged.first_elem;
         rsp_data_in.out_verts      = merged.vert_count;
         rsp_data_in.out_elems      = merged.elem_count;
      end else if (!is_clear && !is_bad && cur.valid) begin
         rsp_data_in.out_first_vert = cur.first_vert;
         rsp_data_in.out_first_elem = cur.first_elem;
         rsp_data_in.out_verts      = cur.vert_count;
         rsp_data_in.out_elems      = cur.elem_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         vert_total_ff <= '0;
         elem_total_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         fwd_valid_ff  <= fwd_valid_in;
         vert_total_ff <= vert_total_in;
         elem_total_ff <= elem_total_in;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (wr.en) begin
         fwd_index_ff <= wr.addr;
         fwd_entry_ff <= merged;
      end
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every accepted beat gives one result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted beat produced no result");

   // a bad index reports an empty slice and changes no total
   a_bad_index_empty: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && is_bad) |=> (rsp_data.out_verts == '0 && rsp_data.out_elems == '0
         && rsp_data.total_verts == $past(vert_total_ff)
         && rsp_data.total_elems == $past(elem_total_ff)))
      else $error("bad index result not empty or totals changed");

   // a clear starts the sweep and zeroes the totals
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.cmd == CMD_CLEAR) |=> busy ##1 (rsp_data.total_verts == '0
         && rsp_data.total_elems == '0))
      else $error("clear did not sweep or zero totals");

   // no table write while the sweep owns the memory
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy |-> !wr.en)
      else $error("table write during sweep");

endmodule

/* dv/vertex_slice_range_merger_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_slice_range_merger_unit_tb
// Self-checking bench for the slice range merger. A scoreboard class keeps
// its own copy of the slice table and the totals. It predicts each result
// from the accepted commands and checks the result beats in order. Stimulus
// is a directed pass over the merge cases, then random add, read and spare traffic that
// is aimed at a few hot slices, with rare clears and out-of-range indexes.
// ----------------------------------------------------------------------------
module vertex_slice_range_merger_unit_tb;
   import vssrm_pkg::*;

   localparam int SLICES       = 1024;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_TAIL   = 150;

   localparam logic [1:0] CMD_SPARE = 2'd3;

   class slice_merge_board;
      logic [31:0] first_vert [SLICES];
      logic [31:0] first_elem [SLICES];
      logic [31:0] vert_count [SLICES];
      logic [31:0] elem_count [SLICES];
      bit          occupied   [SLICES];
      logic [31:0] vert_sum;
      logic [31:0] elem_sum;
      rsp_type     expected_rsp [$];
      int          fails;

      function new();
         foreach (occupied[i]) occupied[i] = 1'b0;
         vert_sum = '0;
         elem_sum = '0;
         fails    = 0;
      endfunction

      function void merge_range(int s, req_type r);
         logic [31:0] old_v, old_e, new_v, new_e, span_v, span_e;
         old_v = occupied[s] ? vert_count[s] : 32'h0;
         old_e = occupied[s] ? elem_count[s] : 32'h0;
         if (!occupied[s] || old_v == 32'h0) begin
            first_vert[s] = r.range_first_vert;
            first_elem[s] = r.range_first_elem;
            new_v = r.range_verts;
            new_e = r.range_elems;
         end else if (r.range_first_vert < first_vert[s]) begin
            new_v = old_v + first_vert[s] - r.range_first_vert;
            new_e = old_e + first_elem[s] - r.range_first_elem;
            first_vert[s] = r.range_first_vert;
            first_elem[s] = r.range_first_elem;
         end else begin
            span_v = r.range_verts + r.range_first_vert - first_vert[s];
            span_e = r.range_elems + r.range_first_elem - first_elem[s];
            new_v = (span_v > old_v) ? span_v : old_v;
            new_e = (span_e > old_e) ? span_e : old_e;
         end
         vert_count[s] = new_v;
         elem_count[s] = new_e;
         occupied[s]   = 1'b1;
         vert_sum = vert_sum + new_v - old_v;
         elem_sum = elem_sum + new_e - old_e;
      endfunction

      function void note_request(req_type r);
         rsp_type want;
         int      s;
         want = '0;
         s    = int'(r.slice_index);
         if (r.cmd == CMD_CLEAR) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            vert_sum = '0;
            elem_sum = '0;
         end else if (s >= SLICES) begin
            want.bad_index = 1'b1;
         end else begin
            if (r.cmd == CMD_ADD) merge_range(s, r);
            if (occupied[s]) begin
               want.out_first_vert = first_vert[s];
               want.out_first_elem = first_elem[s];
               want.out_verts      = vert_count[s];
               want.out_elems      = elem_count[s];
            end
         end
         want.total_verts = vert_sum;
         want.total_elems = elem_sum;
         expected_rsp.push_back(want);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("result beat with no command outstanding");
            fails++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("out_first_vert", want.out_first_vert, got.out_first_vert);
            check_field("out_first_elem", want.out_first_elem, got.out_first_elem);
            check_field("out_verts", want.out_verts, got.out_verts);
            check_field("out_elems", want.out_elems, got.out_elems);
            check_field("total_verts", want.total_verts, got.total_verts);
            check_field("total_elems", want.total_elems, got.total_elems);
            check_field("bad_index", 32'(want.bad_index), 32'(got.bad_index));
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   slice_merge_board sb = new();

   vertex_slice_range_merger_unit #(
      .SLICE_COUNT(SLICES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_response(rsp_data);
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [11:0] idx,
                                        logic [31:0] nv, logic [31:0] ne,
                                        logic [31:0] fv, logic [31:0] fe);
      req_type r;
      r.cmd              = cmd;
      r.slice_index      = idx;
      r.range_verts      = nv;
      r.range_elems      = ne;
      r.range_first_vert = fv;
      r.range_first_elem = fe;
      return r;
   endfunction

   function automatic logic [31:0] pick_word(logic [31:0] base, int spread);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         default: return base + $urandom_range(0, 2 * spread) - spread;
      endcase
   endfunction

   // Mostly adds and reads on a few hot slices at both ends of the table,
   // so merges and same-slice back-to-back beats are common.
   function automatic req_type random_request();
      req_type     r;
      int          roll;
      logic [31:0] anchor;
      roll = $urandom_range(0, 99);
      if (roll < 2) r.cmd = CMD_CLEAR;
      else if (roll < 62) r.cmd = CMD_ADD;
      else if (roll < 92) r.cmd = CMD_READ;
      else r.cmd = CMD_SPARE;
      if ($urandom_range(0, 19) == 0) begin
         r.slice_index = 12'($urandom_range(SLICES, 4095));
      end else if ($urandom_range(0, 4) < 3) begin
         r.slice_index = 12'($urandom_range(0, 3));
         if ($urandom_range(0, 1)) r.slice_index = 12'(SLICES - 1) - r.slice_index;
      end else begin
         r.slice_index = 12'($urandom_range(0, SLICES - 1));
      end
      anchor = 32'(r.slice_index) << 20;
      r.range_first_vert = pick_word(anchor, 300);
      r.range_first_elem = pick_word(anchor + 32'h0004_0000, 300);
      r.range_verts      = pick_word(32'd256, 256);
      r.range_elems      = pick_word(32'd256, 256);
      return r;
   endfunction

   task automatic send_item(req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= random_request();
      end
   endtask

   initial begin
      #50_000_000;
      $display("** vertex_slice_range_merger_unit: FAILED **");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(make_req(CMD_READ, 12'd0, 32'd1, 32'd1, 32'd1, 32'd1));
      send_item(make_req(CMD_ADD, 12'd0, 32'd10, 32'd20, 32'd100, 32'd200));
      send_item(make_req(CMD_ADD, 12'd0, 32'd10, 32'd5, 32'd105, 32'd210));
      send_item(make_req(CMD_ADD, 12'd0, 32'd4, 32'd4, 32'd90, 32'd190));
      send_item(make_req(CMD_READ, 12'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_ADD, 12'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_req(CMD_ADD, 12'd1023, 32'd1, 32'd1, 32'h10, 32'h10));
      send_item(make_req(CMD_ADD, 12'd1023, 32'd2, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_req(CMD_ADD, 12'd5, 32'd0, 32'd7, 32'd50, 32'd60));
      send_item(make_req(CMD_ADD, 12'd5, 32'd3, 32'd3, 32'd70, 32'd80));
      send_item(make_req(CMD_ADD, 12'd1024, 32'd9, 32'd9, 32'd9, 32'd9));
      send_item(make_req(CMD_READ, 12'd4095, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_SPARE, 12'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_SPARE, 12'd2000, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_ADD, 12'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_READ, 12'd2, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_CLEAR, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_req(CMD_READ, 12'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      send_item(make_req(CMD_ADD, 12'd0, 32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF));
      send_item(make_req(CMD_ADD, 12'd0, 32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF));
      send_item(make_req(CMD_ADD, 12'd7, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h0000_0001, 32'hFFFF_FFFE));
      send_item(make_req(CMD_CLEAR, 12'd0, 32'd0, 32'd0, 32'd0, 32'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 7));
         send_item(random_request());
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.fails == 0) begin
         $display("** vertex_slice_range_merger_unit: PASSED **");
      end else begin
         $display("** vertex_slice_range_merger_unit: FAILED **");
      end
      $finish;
   end

endmodule

/* vertex_slice_range_merger_unit.f */
rtl/vssrm_pkg.sv
rtl/vssrm_store.sv
rtl/vssrm_merge.sv
rtl/vertex_slice_range_merger_unit.sv
dv/vertex_slice_range_merger_unit_tb.sv
